// ===== rtl/double_to_float_pair_split_unit_defines.svh =====
// Assertion macros shared by the double-to-float pair split unit.
// Include by bare file name; no other dependencies.
`ifndef DOUBLE_TO_FLOAT_PAIR_SPLIT_UNIT_DEFINES_SVH
`define DOUBLE_TO_FLOAT_PAIR_SPLIT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfs assertion failed");

// Next-cycle implication, disabled in reset.
`define DFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfs assertion failed");

`endif

// ===== rtl/dfs_pkg.sv =====
// Types, constants and rounding functions of the double-to-float pair split unit.
// No dependencies.
package dfs_pkg;

    localparam logic [31:0] SP_INF      = 32'h7F80_0000;
    localparam logic [31:0] SP_DEF_NAN  = 32'hFFC0_0000;
    localparam logic [31:0] SP_SIGN     = 32'h8000_0000;
    localparam int          SIG_W       = 56;
    localparam int          EXP_W       = 14;
    localparam logic [5:0]  SHIFT_NORM  = 6'd32;
    localparam logic [5:0]  SHIFT_MAX   = 6'd58;

    typedef struct packed {
        logic [63:0] pos_x;
        logic [63:0] pos_y;
        logic [63:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic [31:0] high_x;
        logic [31:0] low_x;
        logic [31:0] high_y;
        logic [31:0] low_y;
        logic [31:0] high_z;
        logic [31:0] low_z;
    } split_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    typedef struct packed {
        logic       ovf;
        logic [7:0] field;
        logic [5:0] shift;
    } prep_t;

    typedef struct packed {
        logic [31:0]      word;
        logic             up;
        logic [SIG_W-1:0] rem;
    } fin_t;

    // Value is sig * 2^(e-55); derive biased exponent field and shift (to 24 bits when normal).
    function automatic prep_t rnd_prep(input logic signed [EXP_W-1:0] e);
        logic signed [EXP_W-1:0] fe;
        logic signed [EXP_W-1:0] t;
        prep_t p;
        fe = e + 14'sd127;
        t = 14'sd33 - fe;
        p.ovf = fe >= 14'sd255;
        if (fe >= 14'sd1)
        begin
            p.field = fe[7:0] - 8'd1;
            p.shift = SHIFT_NORM;
        end
        else
        begin
            p.field = 8'd0;
            p.shift = (t > 14'sd58) ? SHIFT_MAX : t[5:0];
        end
        return p;
    endfunction

    // Round to nearest even and pack into a single word.
    function automatic fin_t rnd_fin(input logic sign, input prep_t p,
                                     input logic [SIG_W-1:0] sig);
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] res;
        fin_t f;
        s = {8'd0, sig};
        q = s >> p.shift;
        rem = s & ((64'd1 << p.shift) - 64'd1);
        half = 64'd1 << (p.shift - 6'd1);
        f.up = (rem > half) || ((rem == half) && q[0]);
        q = q + {63'd0, f.up};
        res = {33'd0, p.field, 23'd0} + q;
        f.rem = rem[SIG_W-1:0];
        if (p.ovf || (res >= {32'd0, SP_INF}))
            f.word = {sign, SP_INF[30:0]};
        else
            f.word = {sign, res[30:0]};
        return f;
    endfunction

endpackage

// ===== rtl/double_to_float_pair_split_unit.sv =====
// Usage:
// Top level of the double-to-float pair split unit; splits one xyz position per word.
// Depends on dfs_pkg, dfs_lane and double_to_float_pair_split_unit_defines.svh.
//
// Input channel pos (pos_valid/pos_ready) carries three IEEE-754 doubles.
// Output channel split (split_valid/split_ready) carries a high and a low single
// per component: high is the double rounded to nearest even, low is the rounded
// residual. cfg_we/cfg_wdata write planar_mode; when set, high_z and low_z read +0.
// Write it only while the unit is empty.
// Throughput is one word per cycle while split_ready is high, set by the
// four-stage lane pipeline (decode, high round, normalize, low round), one lane
// per component; split_valid is registered at the output of the last stage.
// When split_ready is low the output stage holds its word; earlier stages keep
// filling empty slots, so pos_ready drops only once all four stages hold words.
// Reset clears all stage valid bits and planar_mode; no flush pass is needed.
`include "double_to_float_pair_split_unit_defines.svh"
module double_to_float_pair_split_unit
    import dfs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pos_valid,
    output logic   pos_ready,
    input  pos_t   pos,
    output logic   split_valid,
    input  logic   split_ready,
    output split_t split,
    input  logic   cfg_we,
    input  logic   cfg_wdata
);

    logic      planar_reg;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      v4_reg;
    stage_en_t en;
    logic [31:0] hx, lx, hy, ly, hz, lz;

    always_comb
    begin
        en.s4 = !v4_reg || split_ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planar_reg <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                planar_reg <= cfg_wdata;
            if (en.s1)
                v1_reg <= pos_valid;
            if (en.s2)
                v2_reg <= v1_reg;
            if (en.s3)
                v3_reg <= v2_reg;
            if (en.s4)
                v4_reg <= v3_reg;
        end
    end

    dfs_lane u_lane_x (.clk(clk), .en(en), .dword(pos.pos_x), .high(hx), .low(lx));
    dfs_lane u_lane_y (.clk(clk), .en(en), .dword(pos.pos_y), .high(hy), .low(ly));
    dfs_lane u_lane_z (.clk(clk), .en(en), .dword(pos.pos_z), .high(hz), .low(lz));

    assign pos_ready    = en.s1;
    assign split_valid  = v4_reg;
    assign split.high_x = hx;
    assign split.low_x  = lx;
    assign split.high_y = hy;
    assign split.low_y  = ly;
    assign split.high_z = planar_reg ? 32'd0 : hz;
    assign split.low_z  = planar_reg ? 32'd0 : lz;

    `DFS_ASSERT_NOW(a_ready_when_out_free, !v4_reg || split_ready, pos_ready)
    `DFS_ASSERT_NOW(a_full_stall_blocks, v1_reg && v2_reg && v3_reg && v4_reg && !split_ready, !pos_ready)
    `DFS_ASSERT_NOW(a_planar_zero, split_valid && planar_reg, split.high_z == 32'd0 && split.low_z == 32'd0)
    `DFS_ASSERT_NOW(a_empty_latency, !v1_reg && !v2_reg && !v3_reg && !v4_reg && pos_valid, ##4 split_valid)

endmodule

// ===== rtl/dfs_lane.sv =====
// Four-stage split of one double into high and low single words.
// Depends on dfs_pkg.
module dfs_lane
    import dfs_pkg::*;
(
    input  logic        clk,
    input  stage_en_t   en,
    input  logic [63:0] dword,
    output logic [31:0] high,
    output logic [31:0] low
);

    // stage 1
    logic                    s1_sign_reg;
    logic signed [EXP_W-1:0] s1_e_reg;
    prep_t                   s1_prep_reg;
    logic [SIG_W-1:0]        s1_sig_reg;
    logic                    s1_special_reg;
    logic [31:0]             s1_sphigh_reg;
    logic [31:0]             s1_splow_reg;

    logic [10:0]             d_exp;
    logic [51:0]             d_man;
    logic signed [EXP_W-1:0] d_e;
    logic [31:0]             d_sphigh;

    always_comb
    begin
        d_exp = dword[62:52];
        d_man = dword[51:0];
        d_e = (d_exp != 11'd0) ? ($signed({3'd0, d_exp}) - 14'sd1023) : -14'sd1022;
        d_sphigh = (d_man == 52'd0) ? {dword[63], SP_INF[30:0]}
                                    : {dword[63], 8'hFF, 1'b1, d_man[50:29]};
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_sign_reg    <= dword[63];
            s1_e_reg       <= d_e;
            s1_prep_reg    <= rnd_prep(d_e);
            s1_sig_reg     <= {(d_exp != 11'd0), d_man, 3'd0};
            s1_special_reg <= d_exp == 11'h7FF;
            s1_sphigh_reg  <= d_sphigh;
            s1_splow_reg   <= (d_man == 52'd0) ? SP_DEF_NAN : d_sphigh;
        end
    end

    // stage 2
    logic [31:0]             s2_high_reg;
    logic                    s2_fixed_reg;
    logic [31:0]             s2_fixw_reg;
    logic [SIG_W-1:0]        s2_mag_reg;
    logic                    s2_sign_reg;
    logic signed [EXP_W-1:0] s2_e_reg;

    fin_t        h_fin;
    logic [63:0] h_mag;

    always_comb
    begin
        h_fin = rnd_fin(s1_sign_reg, s1_prep_reg, s1_sig_reg);
        h_mag = h_fin.up ? ((64'd1 << s1_prep_reg.shift) - {8'd0, h_fin.rem})
                         : {8'd0, h_fin.rem};
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_high_reg  <= s1_special_reg ? s1_sphigh_reg : h_fin.word;
            s2_fixed_reg <= s1_special_reg || (h_fin.word[30:0] == SP_INF[30:0]);
            s2_fixw_reg  <= s1_special_reg ? s1_splow_reg : (h_fin.word ^ SP_SIGN);
            s2_mag_reg   <= h_mag[SIG_W-1:0];
            s2_sign_reg  <= s1_sign_reg ^ h_fin.up;
            s2_e_reg     <= s1_e_reg;
        end
    end

    // stage 3
    logic [31:0]      s3_high_reg;
    logic             s3_fixed_reg;
    logic [31:0]      s3_fixw_reg;
    logic             s3_zero_reg;
    logic             s3_sign_reg;
    prep_t            s3_prep_reg;
    logic [SIG_W-1:0] s3_sig_reg;

    logic [5:0]              r_msb;
    logic [5:0]              r_lz;
    logic signed [EXP_W-1:0] r_e;

    always_comb
    begin
        r_msb = 6'd0;
        for (int i = 0; i < SIG_W; i++)
        begin
            if (s2_mag_reg[i])
                r_msb = 6'(i);
        end
        r_lz = 6'(SIG_W - 1) - r_msb;
        r_e = s2_e_reg - $signed({8'd0, r_lz});
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            s3_high_reg  <= s2_high_reg;
            s3_fixed_reg <= s2_fixed_reg;
            s3_fixw_reg  <= s2_fixw_reg;
            s3_zero_reg  <= s2_mag_reg == '0;
            s3_sign_reg  <= s2_sign_reg;
            s3_prep_reg  <= rnd_prep(r_e);
            s3_sig_reg   <= s2_mag_reg << r_lz;
        end
    end

    // stage 4
    logic [31:0] s4_high_reg;
    logic [31:0] s4_low_reg;
    fin_t        l_fin;

    always_comb
    begin
        l_fin = rnd_fin(s3_sign_reg, s3_prep_reg, s3_sig_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            s4_high_reg <= s3_high_reg;
            if (s3_fixed_reg)
                s4_low_reg <= s3_fixw_reg;
            else if (s3_zero_reg)
                s4_low_reg <= 32'd0;
            else
                s4_low_reg <= l_fin.word;
        end
    end

    assign high = s4_high_reg;
    assign low  = s4_low_reg;

endmodule

// ===== bench/tb_double_to_float_pair_split_unit.sv =====
// Testbench for double_to_float_pair_split_unit: drives xyz double words, checks split words.
// Checks against a behavioral predictor kept in a small scoreboard class.
// Depends on dfs_pkg and the RTL of the unit.
module tb_double_to_float_pair_split_unit;
    import dfs_pkg::*;

    class split_scoreboard;
        split_t expected_q[$];
        bit     planar;
        int     errors;
        int     noted;
        int     checked;

        function logic [31:0] round_to_single(logic [63:0] b);
            logic [31:0] sgn;
            logic [10:0] ex;
            logic [51:0] man;
            logic [63:0] sig, q, rem, half, res;
            int e, fe, sh;
            sgn = {b[63], 31'd0};
            ex = b[62:52];
            man = b[51:0];
            if (ex == 11'h7FF)
            begin
                if (man == 0)
                    return sgn | SP_INF;
                return sgn | SP_INF | 32'h0040_0000 | 32'(man >> 29);
            end
            if (ex == 0 && man == 0)
                return sgn;
            sig = (ex != 0) ? {12'd1, man} : {12'd0, man};
            e = (ex != 0) ? int'(ex) - 1023 : -1022;
            fe = e + 127;
            if (fe >= 255)
                return sgn | SP_INF;
            sh = (fe >= 1) ? 29 : 29 + (1 - fe);
            if (sh >= 55)
                return sgn;
            q = sig >> sh;
            rem = sig & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
            res = (fe >= 1) ? (64'(fe - 1) << 23) : 64'd0;
            res = res + q;
            if (res >= 64'(SP_INF))
                return sgn | SP_INF;
            return sgn | res[31:0];
        endfunction

        function logic [63:0] widen_single(logic [31:0] h);
            logic [22:0] m;
            int k;
            m = h[22:0];
            k = 0;
            if (h[30:23] == 0)
            begin
                if (m == 0)
                    return {h[31], 63'd0};
                while (!m[22])
                begin
                    m = m << 1;
                    k++;
                end
                m = m << 1;
                return {h[31], 11'(896 - k), m, 29'd0};
            end
            return {h[31], 11'(int'(h[30:23]) + 896), m, 29'd0};
        endfunction

        function void split_component(logic [63:0] b, output logic [31:0] hi,
                                      output logic [31:0] lo);
            real diff;
            hi = round_to_single(b);
            if (b[62:52] == 11'h7FF)
                lo = (b[51:0] != 0) ? hi : SP_DEF_NAN;
            else if (hi[30:0] == SP_INF[30:0])
                lo = hi ^ SP_SIGN;
            else
            begin
                diff = $bitstoreal(b) - $bitstoreal(widen_single(hi));
                lo = round_to_single($realtobits(diff));
            end
        endfunction

        function void note(pos_t p);
            split_t s;
            split_component(p.pos_x, s.high_x, s.low_x);
            split_component(p.pos_y, s.high_y, s.low_y);
            if (planar)
            begin
                s.high_z = 32'd0;
                s.low_z = 32'd0;
            end
            else
                split_component(p.pos_z, s.high_z, s.low_z);
            expected_q = {expected_q, s};
            noted++;
        endfunction

        function void check(split_t act);
            split_t exp_w;
            string names[6] = '{"high_x", "low_x", "high_y", "low_y", "high_z", "low_z"};
            checked++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected split word %h", $time, act);
                errors++;
                return;
            end
            exp_w = expected_q.pop_front();
            for (int i = 0; i < 6; i++)
                if (exp_w[(5 - i) * 32 +: 32] !== act[(5 - i) * 32 +: 32])
                begin
                    $display("%0t: %s expected %h actual %h", $time, names[i],
                             exp_w[(5 - i) * 32 +: 32], act[(5 - i) * 32 +: 32]);
                    errors++;
                end
        endfunction
    endclass

    logic   clk;
    logic   rst_n;
    logic   pos_valid;
    logic   pos_ready;
    pos_t   pos;
    logic   split_valid;
    logic   split_ready;
    split_t split;
    logic   cfg_we;
    logic   cfg_wdata;

    split_scoreboard sb;
    int  cycles;
    bit  no_idle;
    bit  long_hold_done;

    double_to_float_pair_split_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos_valid  (pos_valid),
        .pos_ready  (pos_ready),
        .pos        (pos),
        .split_valid(split_valid),
        .split_ready(split_ready),
        .split      (split),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        split_ready = 0;
        forever
        begin
            @(posedge clk);
            if (split_valid && split_ready)
            begin
                sb.check(split);
                hold = no_idle ? 0 : $urandom_range(0, 19);
            end
            if (!long_hold_done && sb.noted >= 400)
            begin
                long_hold_done = 1;
                hold = 300;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                split_ready <= 0;
                hold--;
            end
            else
                split_ready <= 1;
        end
    end

    function automatic logic [63:0] random_double();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: ;
            1, 2, 3: d[62:52] = 11'($urandom_range(1023 - 150, 1023 + 130));
            4: d[62:52] = 11'($urandom_range(1023 - 40, 1023 + 40));
            5: d[62:52] = 11'($urandom_range(896 - 26, 897));
            6:
            begin
                d[62:52] = 11'h7FF;
                if ($urandom_range(0, 2) == 0)
                    d[51:0] = 0;
            end
            7:
            begin
                d[62:52] = 0;
                if ($urandom_range(0, 1) == 0)
                    d[51:0] = 0;
            end
            8:
            begin
                d[62:52] = 11'($urandom_range(1023 + 126, 1023 + 129));
                if ($urandom_range(0, 1) == 0)
                    d[51:29] = '1;
            end
            default:
            begin
                d[62:52] = 11'($urandom_range(1023 - 140, 1023 + 127));
                d[28:0] = ($urandom_range(0, 1) == 0) ? 29'h1000_0000 : 29'd0;
            end
        endcase
        return d;
    endfunction

    task automatic send_position(logic [63:0] x, logic [63:0] y, logic [63:0] z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            pos_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        pos <= '{pos_x: x, pos_y: y, pos_z: z};
        pos_valid <= 1;
        do
            @(posedge clk);
        while (!pos_ready);
        sb.note(pos);
        @(negedge clk);
    endtask

    task automatic drain_unit();
        pos_valid <= 0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_planar(bit v);
        drain_unit();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.planar = v;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_position(random_double(), random_double(), random_double());
        end
        no_idle = 0;
    endtask

    initial
    begin
        logic [63:0] dir[$];
        sb = new();
        cycles = 0;
        no_idle = 0;
        long_hold_done = 0;
        rst_n = 0;
        pos_valid = 0;
        pos = '0;
        cfg_we = 0;
        cfg_wdata = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        dir = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
                64'h3690_0000_0000_0000, 64'h36A0_0000_0000_0001,
                64'h380F_FFFF_F000_0000, 64'h380F_FFFF_FFFF_FFFF,
                64'h47EF_FFFF_E000_0000, 64'h47EF_FFFF_F000_0000,
                64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0001,
                64'hFFF8_0000_2000_0000, 64'h3FF0_0000_1000_0000,
                64'h3FF0_0000_3000_0000, 64'h3FF0_0000_0000_0000,
                64'hBFB9_9999_9999_999A, 64'hFFFF_FFFF_FFFF_FFFF};
        for (int i = 0; i < dir.size(); i++)
            send_position(dir[i], dir[(i + 7) % dir.size()], dir[(i + 13) % dir.size()]);

        run_random(900);
        write_planar(1);
        for (int i = 0; i < 4; i++)
            send_position(dir[i + 10], dir[i], dir[i + 11]);
        run_random(800);
        write_planar(0);
        run_random(130);

        pos_valid <= 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d positions and checked %0d split words across planar on and off,",
                 sb.noted, sb.checked);
        $display("with specials, rounding ties, subnormals, overflow and stalls on both sides.");
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
